>>> rtl/pi128_pkg.sv
// Shared types and character codes for the 128-bit integer parser.
`timescale 1ns / 1ps

package pi128_pkg;

    // Position within the string being parsed.
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_SIGN   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    // Number base selected by the prefix.
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    localparam int ValueWidth = 128;
    localparam int HalfWidth  = 64;

    typedef struct packed {
        phase_t                  phase;
        radix_t                  radix;
        logic                    negative;
        logic                    bad_digit;
        logic [ValueWidth-1:0]   acc;
    } parse_state_t;

    typedef struct packed {
        logic [ValueWidth-1:0]   value;
        logic                    invalid;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_START,
        radix:     RX_DEC,
        negative:  1'b0,
        bad_digit: 1'b0,
        acc:       '0
    };

    // ASCII codes the parser recognizes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

endpackage

>>> rtl/pi128_step.sv
// Next-state and result logic for one character of the integer parser.
`timescale 1ns / 1ps

module pi128_step (
    input  pi128_pkg::parse_state_t  state,
    input  logic [7:0]               char_code,
    output pi128_pkg::parse_state_t  state_next,
    output logic                     term,
    output pi128_pkg::parse_result_t result
);
    import pi128_pkg::*;

    radix_t                radix_eff;
    logic                  lead_zero;
    logic                  prefix_hit;
    logic                  sign_pos;
    logic                  digit_pos;
    logic                  take_digit;
    logic                  set_neg;
    logic [4:0]            digit;
    logic [4:0]            base;
    logic                  digit_ok;
    logic [ValueWidth-1:0] scaled;
    logic [ValueWidth-1:0] mac;
    phase_t                phase_next;
    radix_t                radix_next;
    logic                  negative_next;
    logic                  bad_next;
    logic [ValueWidth-1:0] acc_next;

    assign term = (char_code == CH_NUL);

    // Prefix decode: which base applies to this character and where it sits.
    always_comb
    begin
        radix_eff  = state.radix;
        lead_zero  = 1'b0;
        prefix_hit = 1'b0;
        sign_pos   = 1'b0;
        digit_pos  = 1'b0;
        case (state.phase)
            PH_START:
            begin
                if (char_code == CH_0)
                begin
                    lead_zero = 1'b1;
                end
                else
                begin
                    radix_eff = RX_DEC;
                    sign_pos  = 1'b1;
                end
            end
            PH_ZERO:
            begin
                case (char_code) inside
                    CH_LX, CH_UX:
                    begin
                        radix_eff  = RX_HEX;
                        prefix_hit = 1'b1;
                    end
                    CH_LB, CH_UB:
                    begin
                        radix_eff  = RX_BIN;
                        prefix_hit = 1'b1;
                    end
                    default:
                    begin
                        radix_eff = RX_OCT;
                        sign_pos  = 1'b1;
                    end
                endcase
            end
            PH_SIGN:
            begin
                sign_pos = 1'b1;
            end
            default:
            begin
                digit_pos = 1'b1;
            end
        endcase
    end

    assign set_neg    = sign_pos && (char_code == CH_MINUS);
    assign take_digit = digit_pos
                     || (sign_pos && (char_code != CH_MINUS) && (char_code != CH_PLUS));

    // Digit value; 16 marks a character that is no digit at all.
    always_comb
    begin
        case (char_code) inside
            [CH_0:CH_9]:   digit = 5'(char_code - CH_0);
            [CH_LA:CH_LF]: digit = 5'(char_code - CH_LA + 8'd10);
            [CH_UA:CH_UF]: digit = 5'(char_code - CH_UA + 8'd10);
            default:       digit = 5'd16;
        endcase
    end

    // Multiply by the base as shifts and adds, then add the digit.
    always_comb
    begin
        case (radix_eff)
            RX_HEX:
            begin
                base   = 5'd16;
                scaled = {state.acc[ValueWidth-5:0], 4'b0};
            end
            RX_OCT:
            begin
                base   = 5'd8;
                scaled = {state.acc[ValueWidth-4:0], 3'b0};
            end
            RX_BIN:
            begin
                base   = 5'd2;
                scaled = {state.acc[ValueWidth-2:0], 1'b0};
            end
            default:
            begin
                base   = 5'd10;
                scaled = {state.acc[ValueWidth-4:0], 3'b0}
                       + {state.acc[ValueWidth-2:0], 1'b0};
            end
        endcase
    end

    assign digit_ok = (digit < base);
    assign mac      = scaled + {{(ValueWidth-4){1'b0}}, digit[3:0]};

    // Phase sequencing.
    always_comb
    begin
        if (term)
        begin
            phase_next = PH_START;
        end
        else
        begin
            case (state.phase)
                PH_START: phase_next = lead_zero ? PH_ZERO : PH_DIGITS;
                PH_ZERO:  phase_next = prefix_hit ? PH_SIGN : PH_DIGITS;
                PH_SIGN:  phase_next = PH_DIGITS;
                default:  phase_next = PH_DIGITS;
            endcase
        end
    end

    // Datapath and flags.
    always_comb
    begin
        if (term)
        begin
            radix_next    = RX_DEC;
            negative_next = 1'b0;
            bad_next      = 1'b0;
            acc_next      = '0;
        end
        else
        begin
            radix_next    = radix_eff;
            negative_next = state.negative | set_neg;
            bad_next      = state.bad_digit | (take_digit & ~digit_ok);
            if (take_digit && digit_ok && !state.bad_digit)
            begin
                acc_next = mac;
            end
            else
            begin
                acc_next = state.acc;
            end
        end
    end

    assign state_next = '{
        phase:     phase_next,
        radix:     radix_next,
        negative:  negative_next,
        bad_digit: bad_next,
        acc:       acc_next
    };

    always_comb
    begin
        result.invalid = state.bad_digit;
        if (state.bad_digit)
        begin
            result.value = '0;
        end
        else if (state.negative)
        begin
            result.value = ~state.acc + {{(ValueWidth-1){1'b0}}, 1'b1};
        end
        else
        begin
            result.value = state.acc;
        end
    end

endmodule

>>> rtl/parse_integer_128bit_unit.sv
// Top level of the streaming ASCII to 128-bit integer parser.
// The block takes one ASCII character per request on the char channel and
// builds a 128-bit integer from it. A leading "0x" or "0X" selects hex, "0b"
// or "0B" binary, a leading zero followed by more text octal, and anything
// else decimal; an optional '+' or '-' may follow the prefix. A zero byte
// ends the string: it produces exactly one result request carrying the
// two's complement value (split into value_low and value_high) and the
// invalid flag, and it returns the parser to its start state for the next
// string. Any other character produces no result. A character that is not a
// legal digit for the base forces the value to zero and sets invalid; the
// value wraps modulo 2^128 without any flag. The block sustains one
// character per clock cycle unless a terminator waits for the output
// register. Each accepted character sits in an input register, then goes
// through a single stage where the 128-bit shift-and-add accumulator takes
// it; that stage sets the clock period. The output register holds each
// result, so new characters keep flowing while a result waits for
// result_ready. Only the next terminator has to wait in the input register
// until the output register is free, and while it waits char_ready stays
// low. There is no clearing pass after reset.
`timescale 1ns / 1ps

module parse_integer_128bit_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [63:0] value_low,
    output logic [63:0] value_high,
    output logic        invalid
);
    import pi128_pkg::*;

    logic [7:0]            char_reg;
    logic                  char_valid_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    parse_result_t         step_result;
    logic                  term;
    logic                  advance;
    logic                  load_result;
    logic [ValueWidth-1:0] value_reg;
    logic                  invalid_reg;
    logic                  result_valid_reg;

    // The held character moves into the parser state unless it is a
    // terminator whose result slot is still occupied.
    assign advance     = char_valid_reg && (!term || !result_valid_reg || result_ready);
    assign load_result = advance && term;
    assign char_ready  = !char_valid_reg || advance;

    pi128_step u_step (
        .state      (state_reg),
        .char_code  (char_reg),
        .state_next (state_next),
        .term       (term),
        .result     (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            char_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_code;
        end
    end

    // Parser state, including the accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            value_reg   <= step_result.value;
            invalid_reg <= step_result.invalid;
        end
    end

    assign result_valid = result_valid_reg;
    assign value_low    = value_reg[HalfWidth-1:0];
    assign value_high   = value_reg[ValueWidth-1:HalfWidth];
    assign invalid      = invalid_reg;

`ifndef SYNTHESIS
    // An invalid string always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && invalid) |-> (value_low == '0 && value_high == '0))
        else $error("invalid result with nonzero value");

    // A consumed terminator leaves the parser in its start state.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after terminator");

    // A bad digit stays recorded until the terminator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bad_digit && !load_result) |=> state_reg.bad_digit)
        else $error("bad digit flag lost before terminator");

    // A new result only appears after a terminator was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(load_result))
        else $error("result raised without a terminator");
`endif

endmodule

>>> dv/tb_parse_integer_128bit_unit.sv
// Self-checking testbench for the streaming ASCII to 128-bit integer parser.
`timescale 1ns / 1ps

module tb_parse_integer_128bit_unit;

    import pi128_pkg::*;

    // One parse result as the block presents it on the result channel.
    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        inv;
    } parse_value_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  char_code = 8'h00;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        invalid;

    parse_integer_128bit_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value_low    (value_low),
        .value_high   (value_high),
        .invalid      (invalid)
    );

    // Characters waiting to be offered, and results the parser owes us.
    logic [7:0]   char_queue[$];
    parse_value_t awaited_values[$];

    int  error_count = 0;
    int  chars_accepted = 0;
    int  results_seen = 0;
    logic char_fire = 1'b0;

    // Receiver hold-off bookkeeping: one long stall once a few results are in.
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // Our own copy of the parser state, advanced once per accepted character.
    phase_t         parse_phase = PH_START;
    radix_t         parse_radix = RX_DEC;
    logic           parse_neg = 1'b0;
    logic           parse_bad = 1'b0;
    logic [127:0]   parse_acc = '0;

    // A window of accepted characters during which neither side idles, so that
    // the block also sees back-to-back traffic at full rate.
    wire calm = (chars_accepted >= 600) && (chars_accepted < 1000);

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("tb: mismatch: %s", msg);
        error_count++;
    endtask

    // Digit value of a character, or 16 when it is no digit at all.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 5'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF)
            return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF)
            return 5'(c - CH_UA + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [4:0] radix_base(input radix_t r);
        case (r)
            RX_HEX:  return 5'd16;
            RX_OCT:  return 5'd8;
            RX_BIN:  return 5'd2;
            default: return 5'd10;
        endcase
    endfunction

    // Folds one digit into the accumulator. An illegal digit poisons the
    // string; after that the accumulator is frozen until the terminator.
    task automatic fold_digit(input logic [7:0] c);
        logic [4:0]   base;
        logic [4:0]   d;
        base = radix_base(parse_radix);
        d = digit_value(c);
        if (d >= base) begin
            parse_bad = 1'b1;
        end
        else if (!parse_bad) begin
            parse_acc = parse_acc * {123'd0, base} + {123'd0, d};
        end
    endtask

    // The character right after the prefix may be a sign; anything else is
    // already the first digit.
    task automatic take_sign_slot(input logic [7:0] c);
        parse_phase = PH_DIGITS;
        if (c == CH_MINUS)
            parse_neg = 1'b1;
        else if (c != CH_PLUS)
            fold_digit(c);
    endtask

    // Advances the predicted parser by one character. A terminator queues the
    // expected result and returns the state to its start values.
    task automatic parse_char(input logic [7:0] c);
        parse_value_t res;
        logic [127:0] v;
        if (c == CH_NUL) begin
            if (parse_bad)
                v = '0;
            else if (parse_neg)
                v = ~parse_acc + 128'd1;
            else
                v = parse_acc;
            res.lo = v[63:0];
            res.hi = v[127:64];
            res.inv = parse_bad;
            awaited_values.push_back(res);
            parse_phase = PH_START;
            parse_radix = RX_DEC;
            parse_neg = 1'b0;
            parse_bad = 1'b0;
            parse_acc = '0;
        end
        else begin
            case (parse_phase)
                PH_START: begin
                    if (c == CH_0) begin
                        parse_phase = PH_ZERO;
                    end
                    else begin
                        parse_radix = RX_DEC;
                        take_sign_slot(c);
                    end
                end
                PH_ZERO: begin
                    // A leading zero followed by anything but a hex or binary
                    // marker means octal, and that character is reused.
                    if (c == CH_LX || c == CH_UX) begin
                        parse_radix = RX_HEX;
                        parse_phase = PH_SIGN;
                    end
                    else if (c == CH_LB || c == CH_UB) begin
                        parse_radix = RX_BIN;
                        parse_phase = PH_SIGN;
                    end
                    else begin
                        parse_radix = RX_OCT;
                        take_sign_slot(c);
                    end
                end
                PH_SIGN: take_sign_slot(c);
                default: fold_digit(c);
            endcase
        end
    endtask

    // Queues a literal string followed by its terminator.
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_queue.push_back(s[i]);
        char_queue.push_back(CH_NUL);
    endtask

    // Queues random strings until about n characters are pending. Most are
    // well-formed numbers with random prefix, sign and digits; some have one
    // character replaced by a random byte, and some are pure noise.
    task automatic push_random_strings(input int n);
        int         pushed;
        int         kind;
        int         ndig;
        int         sgn;
        int         v;
        int         bad_pos;
        radix_t     r;
        logic [4:0] base;
        logic [7:0] txt[$];
        pushed = 0;
        while (pushed < n) begin
            txt.delete();
            kind = $urandom_range(99);
            if (kind < 10) begin
                ndig = $urandom_range(6);
                for (int i = 0; i < ndig; i++)
                    txt.push_back(8'($urandom_range(255, 1)));
            end
            else begin
                r = radix_t'($urandom_range(3));
                base = radix_base(r);
                case (r)
                    RX_HEX: begin
                        txt.push_back(CH_0);
                        txt.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    end
                    RX_BIN: begin
                        txt.push_back(CH_0);
                        txt.push_back($urandom_range(1) ? CH_LB : CH_UB);
                    end
                    RX_OCT: txt.push_back(CH_0);
                    default: ;
                endcase
                sgn = $urandom_range(5);
                if (sgn < 2)
                    txt.push_back(CH_MINUS);
                else if (sgn == 2)
                    txt.push_back(CH_PLUS);
                // Occasional long strings run the value past 2^128.
                if ($urandom_range(9) == 0)
                    ndig = $urandom_range((base == 5'd2) ? 140 : 45, 20);
                else
                    ndig = $urandom_range(12);
                for (int i = 0; i < ndig; i++) begin
                    v = $urandom_range(int'(base) - 1);
                    // An unsigned decimal string must not open with a zero,
                    // or it would be read as octal.
                    if (r == RX_DEC && sgn > 2 && i == 0 && v == 0)
                        v = 1;
                    if (v < 10)
                        txt.push_back(8'(CH_0 + v));
                    else
                        txt.push_back(8'(($urandom_range(1) ? CH_LA : CH_UA) + v - 10));
                end
                if (kind < 22 && txt.size() > 0) begin
                    bad_pos = $urandom_range(txt.size() - 1);
                    txt[bad_pos] = 8'($urandom_range(255, 1));
                end
            end
            txt.push_back(CH_NUL);
            pushed += txt.size();
            foreach (txt[i])
                char_queue.push_back(txt[i]);
        end
    endtask

    // Lets the queue empty and every owed result arrive. This is also the
    // sender pause: nothing new is offered until the block has gone quiet.
    task automatic drain;
        while (char_queue.size() != 0 || char_valid)
            @(posedge clk);
        while (awaited_values.size() != 0)
            @(posedge clk);
    endtask

    // Request acceptance on the char channel: this is where the prediction
    // advances, one character per accepted request.
    always @(posedge clk) begin
        if (!rst_n) begin
            char_fire <= 1'b0;
        end
        else begin
            char_fire <= char_valid && char_ready;
            if (char_valid && char_ready) begin
                parse_char(char_code);
                chars_accepted++;
            end
        end
    end

    // Driver: changes the char channel at the falling edge only. A new
    // request is offered once the previous one is taken, or when idle; the
    // payload holds still while valid waits for ready.
    always @(negedge clk) begin
        if (!rst_n) begin
            char_valid <= 1'b0;
        end
        else if (!char_valid || char_fire) begin
            if (char_queue.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
                char_valid <= 1'b1;
                char_code <= char_queue.pop_front();
            end
            else begin
                char_valid <= 1'b0;
            end
        end
    end

    // Result ready: random back-pressure, plus a single long hold-off once
    // enough results have passed. During the hold-off the driver keeps
    // offering characters, so the output register and the pipeline fill and
    // the block has to drop char_ready.
    always @(negedge clk) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 30) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // Monitor: each accepted result request is checked against the oldest
    // prediction, field by field.
    always @(posedge clk) begin
        parse_value_t want;
        if (rst_n && result_valid && result_ready) begin
            results_seen++;
            if (awaited_values.size() == 0) begin
                flag_error($sformatf("result with nothing owed: low %h high %h invalid %b",
                                     value_low, value_high, invalid));
            end
            else begin
                want = awaited_values.pop_front();
                if (value_low !== want.lo)
                    flag_error($sformatf("result %0d value_low %h, want %h",
                                         results_seen, value_low, want.lo));
                if (value_high !== want.hi)
                    flag_error($sformatf("result %0d value_high %h, want %h",
                                         results_seen, value_high, want.hi));
                if (invalid !== want.inv)
                    flag_error($sformatf("result %0d invalid %b, want %b",
                                         results_seen, invalid, want.inv));
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings: empty string, lone zero, sign with no digits,
        // negative hex with mixed-case letters, binary with a plus sign,
        // negative octal, a sign in the digit position, and the top byte
        // value as an illegal character.
        push_text("");
        push_text("0");
        push_text("-");
        push_text("0x-aF");
        push_text("0B+1");
        push_text("0-7");
        push_text("1-");
        char_queue.push_back(8'hFF);
        char_queue.push_back(CH_NUL);
        drain();

        push_random_strings(850);
        drain();
        push_random_strings(850);
        drain();

        // Give any stray result a chance to show up.
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a run that never finishes is reported as a failure.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
